// ----- src/audio_rate_fallback_select_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sample-rate fallback selector
// Shorthand for clocked implication checks disabled by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_RATE_FALLBACK_SELECT_MACROS_SVH
`define AUDIO_RATE_FALLBACK_SELECT_MACROS_SVH

// Same-cycle implication
`define ARFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ARFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/arfs_pkg.sv -----
// ----------------------------------------------------------------------------
// arfs_pkg
// Shared types and constants of the sample-rate fallback selector.
// ----------------------------------------------------------------------------
package arfs_pkg;

  // Default sizing
  localparam int DEF_SPANS     = 8;
  localparam int DEF_RATE_BITS = 20;

  // Fixed field widths
  localparam int SLOT_W     = 3;
  localparam int CH_W       = 8;
  localparam int MODE_W     = 2;
  localparam int CNT_REG_W  = 4;
  localparam int REG_IDX_W  = 2;
  localparam int CAND_W     = 3;
  // Headroom for the largest multiply (x8)
  localparam int MUL_BITS   = 3;

  // Input operations
  localparam logic OP_DECIDE     = 1'b0;
  localparam logic OP_SPAN_WRITE = 1'b1;

  // Rate modes
  localparam logic [MODE_W-1:0] MODE_RESAMPLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BITPERFECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FORCE      = 2'd2;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_RATE_MODE      = 2'd0,
    REG_SWITCH_ALLOWED = 2'd1,
    REG_STANDING_RATE  = 2'd2,
    REG_SPAN_COUNT     = 2'd3
  } reg_idx_t;

  // Candidate order in bit-perfect mode
  localparam logic [CAND_W-1:0] CAND_EXACT = 3'd0;
  localparam logic [CAND_W-1:0] CAND_DIV2  = 3'd1;
  localparam logic [CAND_W-1:0] CAND_DIV4  = 3'd2;
  localparam logic [CAND_W-1:0] CAND_DIV8  = 3'd3;
  localparam logic [CAND_W-1:0] CAND_DIV16 = 3'd4;
  localparam logic [CAND_W-1:0] CAND_MUL2  = 3'd5;
  localparam logic [CAND_W-1:0] CAND_MUL4  = 3'd6;
  localparam logic [CAND_W-1:0] CAND_MUL8  = 3'd7;
  localparam logic [CAND_W-1:0] CAND_LAST  = CAND_MUL8;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_BELOW = 5'b00100,
    ST_ABOVE = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // Flags from the shared span comparator
  typedef struct packed {
    logic in_span;        // operand inside [low, high]
    logic high_below;     // high < operand
    logic low_above;      // low > operand
    logic high_over_best; // high > best
    logic low_under_best; // low < best
  } cmp_res_t;

endpackage

// ----- src/audio_rate_fallback_select.sv -----
// ----------------------------------------------------------------------------
// audio_rate_fallback_select
// Picks the device sample rate for a source and flags switch, resample and
// sink reconfiguration, using a loaded table of advertised rate spans.
// ----------------------------------------------------------------------------
// A span write is taken while idle. A decide transaction goes straight to the
// result state except in bit-perfect mode with switching allowed and n > 0
// spans in use; there a single span comparator visits one table entry per
// cycle, trying each candidate rate in turn (exact, /2, /4, /8, /16, x2, x4,
// x8; a candidate that cannot exist is passed over without a span scan), then
// searching below the source and, if nothing is found, above it, before the
// result register is loaded. The input is not ready until the result of the
// current decide is loaded; a result may wait on the output while the next
// transaction is taken.
module audio_rate_fallback_select import arfs_pkg::*; #(
  parameter int SPANS     = DEF_SPANS,
  parameter int RATE_BITS = DEF_RATE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [RATE_BITS-1:0] cfg_wdata,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [SLOT_W-1:0]    in_span_slot,
  input  logic [RATE_BITS-1:0] in_span_low,
  input  logic [RATE_BITS-1:0] in_span_high,
  input  logic [RATE_BITS-1:0] in_source_rate,
  input  logic [CH_W-1:0]      in_source_channels,
  input  logic                 in_open_valid,
  input  logic [RATE_BITS-1:0] in_open_rate,
  input  logic [CH_W-1:0]      in_open_channels,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RATE_BITS-1:0] out_chosen_rate,
  output logic                 out_switch_needed,
  output logic                 out_resample_needed,
  output logic                 out_reconfigure_needed,
  output logic                 out_keep_sink
);

`include "audio_rate_fallback_select_macros.svh"

  localparam int IDX_W = (SPANS > 1) ? $clog2(SPANS) : 1;
  localparam int CNT_W = $clog2(SPANS + 1);
  localparam int CW    = RATE_BITS + MUL_BITS;

  // Configuration registers
  logic [MODE_W-1:0]    rate_mode_r;
  logic                 switch_allowed_r;
  logic [RATE_BITS-1:0] standing_rate_r;
  logic [CNT_REG_W-1:0] span_count_r;

  // Sequencer state
  state_t               state_r, state_nxt;
  logic [CAND_W-1:0]    cand_idx_r, cand_idx_nxt;
  logic [IDX_W-1:0]     span_idx_r, span_idx_nxt;
  logic [RATE_BITS-1:0] best_r, best_nxt;
  logic [RATE_BITS-1:0] pick_r, pick_nxt;
  logic                 found_r, found_nxt;

  // Latched decide transaction
  logic [RATE_BITS-1:0] src_r;
  logic [CH_W-1:0]      src_ch_r;
  logic                 open_ok_r;
  logic [RATE_BITS-1:0] open_rate_r;
  logic [CH_W-1:0]      open_ch_r;

  // Output register
  logic                 out_valid_r;
  logic [RATE_BITS-1:0] out_rate_r;
  logic                 out_sw_r;
  logic                 out_rs_r;
  logic                 out_rc_r;

  logic                 in_fire;
  logic                 decide_fire;
  logic                 tbl_we;
  logic [CNT_W-1:0]     n_use;
  logic                 span_last;
  logic                 cand_ok;
  logic [CW-1:0]        cand_val;
  logic [CW-1:0]        src_x;
  logic [RATE_BITS-1:0] rd_low;
  logic [RATE_BITS-1:0] rd_high;
  cmp_res_t             cmp;
  logic [RATE_BITS-1:0] best_upd;
  logic                 out_load;
  logic [RATE_BITS-1:0] dev_sel;
  logic [RATE_BITS-1:0] dev;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign decide_fire = in_fire && (in_op == OP_DECIDE);
  assign tbl_we      = in_fire && (in_op == OP_SPAN_WRITE) && (int'(in_span_slot) < SPANS);

  // Clamp span count to the table size
  always_comb begin
    if (int'(span_count_r) >= SPANS) begin
      n_use = CNT_W'(SPANS);
    end else begin
      n_use = CNT_W'(span_count_r);
    end
  end

  assign span_last = (CNT_W'(span_idx_r) == (n_use - CNT_W'(1)));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_mode_r      <= MODE_BITPERFECT;
      switch_allowed_r <= 1'b0;
      standing_rate_r  <= '0;
      span_count_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_MODE:      rate_mode_r      <= cfg_wdata[MODE_W-1:0];
        REG_SWITCH_ALLOWED: switch_allowed_r <= cfg_wdata[0];
        REG_STANDING_RATE:  standing_rate_r  <= cfg_wdata;
        REG_SPAN_COUNT:     span_count_r     <= cfg_wdata[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Address the table with span_idx_nxt so its registered data lines up with span_idx_r
  arfs_span_table #(
    .SPANS     (SPANS),
    .RATE_BITS (RATE_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_idx  (IDX_W'(in_span_slot)),
    .wr_low  (in_span_low),
    .wr_high (in_span_high),
    .rd_idx  (span_idx_nxt),
    .rd_low  (rd_low),
    .rd_high (rd_high)
  );

  // Form the candidate rate under test
  assign src_x = {{MUL_BITS{1'b0}}, src_r};

  always_comb begin
    cand_ok  = 1'b0;
    cand_val = src_x;
    case (cand_idx_r)
      CAND_EXACT: begin
        cand_ok  = 1'b1;
        cand_val = src_x;
      end
      CAND_DIV2: begin
        cand_ok  = !src_r[0] && (|src_r[RATE_BITS-1:1]);
        cand_val = src_x >> 1;
      end
      CAND_DIV4: begin
        cand_ok  = (src_r[1:0] == 2'b00) && (|src_r[RATE_BITS-1:2]);
        cand_val = src_x >> 2;
      end
      CAND_DIV8: begin
        cand_ok  = (src_r[2:0] == 3'b000) && (|src_r[RATE_BITS-1:3]);
        cand_val = src_x >> 3;
      end
      CAND_DIV16: begin
        cand_ok  = (src_r[3:0] == 4'b0000) && (|src_r[RATE_BITS-1:4]);
        cand_val = src_x >> 4;
      end
      CAND_MUL2: begin
        cand_ok  = |src_r;
        cand_val = src_x << 1;
      end
      CAND_MUL4: begin
        cand_ok  = |src_r;
        cand_val = src_x << 2;
      end
      CAND_MUL8: begin
        cand_ok  = |src_r;
        cand_val = src_x << 3;
      end
      default: begin
        cand_ok  = 1'b0;
        cand_val = src_x;
      end
    endcase
  end

  arfs_cmp_unit #(
    .RATE_BITS (RATE_BITS)
  ) u_cmp (
    .operand   (cand_val),
    .span_low  (rd_low),
    .span_high (rd_high),
    .best      (best_r),
    .res       (cmp)
  );

  // Running best for the below and above searches
  always_comb begin
    best_upd = best_r;
    if (state_r == ST_BELOW) begin
      if (cmp.high_below && cmp.high_over_best) begin
        best_upd = rd_high;
      end
    end else if (cmp.low_above && ((best_r == '0) || cmp.low_under_best)) begin
      best_upd = rd_low;
    end
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cand_idx_nxt = cand_idx_r;
    span_idx_nxt = span_idx_r;
    best_nxt     = best_r;
    pick_nxt     = pick_r;
    found_nxt    = found_r;
    case (state_r)
      ST_IDLE: begin
        if (decide_fire) begin
          cand_idx_nxt = CAND_EXACT;
          span_idx_nxt = '0;
          best_nxt     = '0;
          found_nxt    = 1'b0;
          pick_nxt     = in_source_rate;
          if ((rate_mode_r == MODE_BITPERFECT) && switch_allowed_r && (n_use != '0)) begin
            state_nxt = ST_SCAN;
          end else begin
            found_nxt = (rate_mode_r == MODE_FORCE) && switch_allowed_r;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (cand_ok && cmp.in_span) begin
          found_nxt = 1'b1;
          pick_nxt  = cand_val[RATE_BITS-1:0];
          state_nxt = ST_OUT;
        end else if (!cand_ok || span_last) begin
          // Advance to the next candidate, or to the below search after the last one
          span_idx_nxt = '0;
          if (cand_idx_r == CAND_LAST) begin
            cand_idx_nxt = CAND_EXACT;
            best_nxt     = '0;
            state_nxt    = ST_BELOW;
          end else begin
            cand_idx_nxt = cand_idx_r + CAND_W'(1);
          end
        end else begin
          span_idx_nxt = span_idx_r + IDX_W'(1);
        end
      end
      ST_BELOW: begin
        best_nxt = best_upd;
        if (span_last) begin
          span_idx_nxt = '0;
          if (best_upd != '0) begin
            found_nxt = 1'b1;
            pick_nxt  = best_upd;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_ABOVE;
          end
        end else begin
          span_idx_nxt = span_idx_r + IDX_W'(1);
        end
      end
      ST_ABOVE: begin
        best_nxt = best_upd;
        if (span_last) begin
          span_idx_nxt = '0;
          found_nxt    = (best_upd != '0);
          pick_nxt     = best_upd;
          state_nxt    = ST_OUT;
        end else begin
          span_idx_nxt = span_idx_r + IDX_W'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_idx_r <= cand_idx_nxt;
    span_idx_r <= span_idx_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    found_r    <= found_nxt;
  end

  // Hold the decide transaction fields
  always_ff @(posedge clk) begin
    if (decide_fire) begin
      src_r       <= in_source_rate;
      src_ch_r    <= in_source_channels;
      open_ok_r   <= in_open_valid;
      open_rate_r <= in_open_rate;
      open_ch_r   <= in_open_channels;
    end
  end

  // Resolve the device rate; a zero rate falls back to the source rate
  assign dev_sel = found_r ? pick_r : standing_rate_r;
  assign dev     = (dev_sel == '0) ? src_r : dev_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rate_r <= dev;
      out_sw_r   <= found_r && (pick_r != standing_rate_r);
      out_rs_r   <= dev != src_r;
      out_rc_r   <= !open_ok_r || (open_rate_r != dev) || (open_ch_r != src_ch_r);
    end
  end

  assign out_valid              = out_valid_r;
  assign out_chosen_rate        = out_rate_r;
  assign out_switch_needed      = out_sw_r;
  assign out_resample_needed    = out_rs_r;
  assign out_reconfigure_needed = out_rc_r;
  assign out_keep_sink          = !out_rc_r;

  // Checks
  `ARFS_ASSERT_NEXT(a_load_from_out, clk, rst_n, out_load, (out_valid_r && (state_r == ST_IDLE)), "result load did not raise valid and release the input")
  `ARFS_ASSERT_IMPLY(a_switch_differs, clk, rst_n, (out_valid_r && out_sw_r), (out_rate_r != standing_rate_r), "switch flagged with chosen rate equal to standing rate")
  `ARFS_ASSERT_IMPLY(a_scan_in_range, clk, rst_n, ((state_r == ST_SCAN) || (state_r == ST_BELOW) || (state_r == ST_ABOVE)), (CNT_W'(span_idx_r) < n_use), "span scan index beyond spans in use")

endmodule

// ----- src/arfs_span_table.sv -----
// ----------------------------------------------------------------------------
// arfs_span_table
// Storage for the advertised rate spans, one write and one registered read
// port. The read data is registered, so it returns the entry addressed in the cycle before.
// ----------------------------------------------------------------------------
module arfs_span_table import arfs_pkg::*; #(
  parameter int SPANS     = DEF_SPANS,
  parameter int RATE_BITS = DEF_RATE_BITS,
  localparam int IDX_W    = (SPANS > 1) ? $clog2(SPANS) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [RATE_BITS-1:0] wr_low,
  input  logic [RATE_BITS-1:0] wr_high,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [RATE_BITS-1:0] rd_low,
  output logic [RATE_BITS-1:0] rd_high
);

  logic [RATE_BITS-1:0] low_mem [SPANS];
  logic [RATE_BITS-1:0] high_mem [SPANS];
  logic [RATE_BITS-1:0] rd_low_r;
  logic [RATE_BITS-1:0] rd_high_r;

  // Store one span entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      low_mem[wr_idx]  <= wr_low;
      high_mem[wr_idx] <= wr_high;
    end
  end

  // Fetch the entry to be scanned in the next cycle
  always_ff @(posedge clk) begin
    rd_low_r  <= low_mem[rd_idx];
    rd_high_r <= high_mem[rd_idx];
  end

  // Present the entry under scan
  assign rd_low  = rd_low_r;
  assign rd_high = rd_high_r;

endmodule

// ----- src/arfs_cmp_unit.sv -----
// ----------------------------------------------------------------------------
// arfs_cmp_unit
// Shared comparator: checks one operand and one running best against a span.
// ----------------------------------------------------------------------------
module arfs_cmp_unit import arfs_pkg::*; #(
  parameter int RATE_BITS = DEF_RATE_BITS,
  localparam int CW       = RATE_BITS + MUL_BITS
) (
  input  logic [CW-1:0]        operand,
  input  logic [RATE_BITS-1:0] span_low,
  input  logic [RATE_BITS-1:0] span_high,
  input  logic [RATE_BITS-1:0] best,
  output cmp_res_t             res
);

  logic [CW-1:0] low_x;
  logic [CW-1:0] high_x;

  assign low_x  = {{MUL_BITS{1'b0}}, span_low};
  assign high_x = {{MUL_BITS{1'b0}}, span_high};

  // Compare operand and best against the span bounds
  always_comb begin
    res.in_span        = (operand >= low_x) && (operand <= high_x);
    res.high_below     = high_x < operand;
    res.low_above      = low_x > operand;
    res.high_over_best = span_high > best;
    res.low_under_best = span_low < best;
  end

endmodule
